@@ hw/rtl/aqc_pkg.sv @@
// ----------------------------------------------------------------------------
// aqc_pkg
// Shared types and constants for the array queue with compaction.
// ----------------------------------------------------------------------------
package aqc_pkg;

  // slots in the entry store; position and count widths are sized for it
  localparam int DEPTH    = 32;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  // operation codes carried by an input transaction
  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // status codes carried by a result transaction
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

@@ hw/rtl/aqc_ram.sv @@
// ----------------------------------------------------------------------------
// aqc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/array_queue_with_compaction_top.sv @@
// ----------------------------------------------------------------------------
// array_queue_with_compaction_top
// Queue of signed words in a linear RAM with head slot and occupancy count.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | to block  | in_valid / in_ready  | operation, value
//  out     | from block| out_valid / out_ready| status, position, count,
//          |           |                      | is_empty, is_full
//
//  enqueue without compaction, dequeue, clear and rejected requests go from
//  the idle state through the finish state to the output register; a search
//  walks the live entries up to the first match and a compacting enqueue walks
//  them all, one entry per cycle through the single RAM read port. one input
//  transaction is in work at a time; in_ready is high while idle, even while an
//  earlier result waits on out_ready. a result that finds the output register
//  still full waits for it.
//  rst is synchronous: head, count and control return to zero, RAM is untouched.
//
module array_queue_with_compaction_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [aqc_pkg::OP_W-1:0]            operation,
  input  logic signed [aqc_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [aqc_pkg::STATUS_W-1:0]        status,
  output logic [aqc_pkg::POS_W-1:0]           position,
  output logic [aqc_pkg::COUNT_W-1:0]         count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int AW = $clog2(aqc_pkg::DEPTH);
  localparam int CW = $clog2(aqc_pkg::DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(aqc_pkg::DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state;

  // queue descriptor
  logic [AW-1:0] head;
  logic [CW-1:0] occ;

  // item in work
  logic signed [aqc_pkg::VALUE_W-1:0] val_q;
  logic [CW-1:0]                      idx;       // next entry to read
  logic                               pend;      // a read is returning this cycle
  logic [AW-1:0]                      pend_addr; // compaction target or search slot
  aqc_pkg::status_t                   res_status;
  logic [AW-1:0]                      res_pos;

  // RAM port signals
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [aqc_pkg::VALUE_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [aqc_pkg::VALUE_W-1:0] ram_rdata;

  logic in_acc;
  logic need_cmp;
  logic walk_more;
  logic hit;
  logic out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  // tail sits at the last slot while the head has moved up
  assign need_cmp  = (head != '0) && ((CW'(head) + occ) == FULL_CNT);
  assign walk_more = (idx < occ);
  assign hit       = pend && (ram_rdata == val_q);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(CW'(head) + occ);
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = AW'(CW'(head) + idx);
    unique case (state)
      S_IDLE: begin
        // plain enqueue writes straight at the tail
        ram_we    = in_acc && (aqc_pkg::op_t'(operation) == aqc_pkg::OP_ENQ)
                    && (occ != FULL_CNT) && !need_cmp;
        ram_wdata = value;
      end
      S_COMPACT: begin
        ram_re = walk_more;
        if (pend) begin
          // move the returned word down; reads run ahead of writes
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = ram_rdata;
        end else if (!walk_more) begin
          // live entries now start at slot 0, append the new word
          ram_we    = 1'b1;
          ram_waddr = AW'(occ);
        end
      end
      S_SEARCH: begin
        ram_re = walk_more && !hit;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  aqc_ram #(
    .WIDTH (aqc_pkg::VALUE_W),
    .DEPTH (aqc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in the finish state a taken result is replaced by the new one below
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            val_q   <= value;
            idx     <= '0;
            pend    <= 1'b0;
            res_pos <= '0;
            unique case (aqc_pkg::op_t'(operation))
              aqc_pkg::OP_ENQ: begin
                if (occ == FULL_CNT) begin
                  res_status <= aqc_pkg::ST_FULL;
                  state      <= S_FINISH;
                end else if (need_cmp) begin
                  state <= S_COMPACT;
                end else begin
                  occ        <= occ + CW'(1);
                  res_status <= aqc_pkg::ST_DONE;
                  state      <= S_FINISH;
                end
              end
              aqc_pkg::OP_DEQ: begin
                if (occ == '0) begin
                  res_status <= aqc_pkg::ST_EMPTY;
                end else begin
                  occ        <= occ - CW'(1);
                  head       <= (occ == CW'(1)) ? '0 : head + AW'(1);
                  res_status <= aqc_pkg::ST_DONE;
                end
                state <= S_FINISH;
              end
              aqc_pkg::OP_SEARCH: begin
                if (occ == '0) begin
                  res_status <= aqc_pkg::ST_EMPTY;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SEARCH;
                end
              end
              aqc_pkg::OP_CLEAR: begin
                head       <= '0;
                occ        <= '0;
                res_status <= aqc_pkg::ST_DONE;
                state      <= S_FINISH;
              end
              default: begin
              end
            endcase
          end
        end

        S_COMPACT: begin
          pend      <= walk_more;
          pend_addr <= AW'(idx);
          if (walk_more) begin
            idx <= idx + CW'(1);
          end
          if (!walk_more && !pend) begin
            head       <= '0;
            occ        <= occ + CW'(1);
            res_status <= aqc_pkg::ST_DONE;
            state      <= S_FINISH;
          end
        end

        S_SEARCH: begin
          pend      <= walk_more;
          pend_addr <= ram_raddr;
          if (walk_more) begin
            idx <= idx + CW'(1);
          end
          if (hit) begin
            pend       <= 1'b0;
            res_status <= aqc_pkg::ST_DONE;
            res_pos    <= pend_addr;
            state      <= S_FINISH;
          end else if (!pend && !walk_more) begin
            res_status <= aqc_pkg::ST_NOT_FOUND;
            state      <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            position  <= aqc_pkg::POS_W'(res_pos);
            count     <= aqc_pkg::COUNT_W'(occ);
            is_empty  <= (occ == '0);
            is_full   <= (occ == FULL_CNT);
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/aqc_checker.sv @@
// ----------------------------------------------------------------------------
// aqc_checker
// Port-level checks on the result transactions of the array queue.
// ----------------------------------------------------------------------------
module aqc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [aqc_pkg::STATUS_W-1:0]       status,
  input logic [aqc_pkg::POS_W-1:0]          position,
  input logic [aqc_pkg::COUNT_W-1:0]        count,
  input logic                               is_empty,
  input logic                               is_full
);

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

  // a full-rejected enqueue reports a full queue
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == aqc_pkg::ST_FULL)) |-> (is_full && !is_empty))
    else $error("full rejection without full queue");

  // an empty-rejected request reports an empty queue
  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == aqc_pkg::ST_EMPTY)) |-> (is_empty && (position == '0)))
    else $error("empty rejection with live entries");

  // a failed search reports slot 0 and a non-empty queue
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == aqc_pkg::ST_NOT_FOUND)) |-> ((position == '0) && !is_empty))
    else $error("not-found result with bad position or empty queue");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(count) && $stable(status)))
    else $error("result changed while stalled");

endmodule

bind array_queue_with_compaction_top aqc_checker u_aqc_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the array queue with compaction: a short scripted
// sequence, then random bursts, each result matched against a queue model.
// ----------------------------------------------------------------------------
module tb;

  localparam int QDEPTH     = aqc_pkg::DEPTH;
  localparam int RAND_ITEMS = 1800;
  localparam int STALL_MAX  = 11;
  // drain wait after the last result, sized from the queue depth to cover the longest walk
  localparam int DRAIN_CYC  = QDEPTH + 8;
  // sender gap + longest walk + receiver stall, taken many times over
  localparam int HANG_LIMIT = 2000;
  localparam int SCRIPT_LEN = 25;

  // one result transaction as the block reports it
  typedef struct packed {
    aqc_pkg::status_t            st;
    logic [aqc_pkg::POS_W-1:0]   pos;
    logic [aqc_pkg::COUNT_W-1:0] cnt;
    logic                        empty;
    logic                        full;
  } qres_t;

  // one scripted row; reps > 1 sends consecutive words starting at word
  typedef struct {
    aqc_pkg::op_t op;
    logic [31:0]  word;
    int           reps;
    bit           pinned;
    qres_t        res;
  } stim_row_t;

  localparam qres_t NOPIN = '{aqc_pkg::ST_DONE, 5'd0, 6'd0, 1'b0, 1'b0};

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [aqc_pkg::OP_W-1:0]           operation = aqc_pkg::OP_ENQ;
  logic signed [aqc_pkg::VALUE_W-1:0] value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [aqc_pkg::STATUS_W-1:0]       status;
  logic [aqc_pkg::POS_W-1:0]          position;
  logic [aqc_pkg::COUNT_W-1:0]        count;
  logic                               is_empty;
  logic                               is_full;

  // typed expectation riding along with the payload of the current transaction
  logic  pinned = 1'b0;
  qres_t pinned_res = NOPIN;

  // queue model state
  logic [31:0] q_words [QDEPTH];
  int          q_head = 0;
  int          q_fill = 0;

  qres_t       pending_results [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  logic [31:0] word_pool [8];

  array_queue_with_compaction_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position),
    .count     (count),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one request to the queue model and return what the block must report
  function automatic qres_t queue_apply(aqc_pkg::op_t op, logic [31:0] w);
    qres_t r;
    int    k;
    bit    hit;
    r = NOPIN;
    hit = 1'b0;
    case (op)
      aqc_pkg::OP_ENQ: begin
        if (q_fill >= QDEPTH) begin
          r.st = aqc_pkg::ST_FULL;
        end else begin
          // tail sits on the last slot with free room below the head: slide down
          if (q_head + q_fill >= QDEPTH && q_head > 0) begin
            for (k = 0; k < q_fill; k++) q_words[k] = q_words[q_head + k];
            q_head = 0;
          end
          q_words[q_head + q_fill] = w;
          q_fill++;
        end
      end
      aqc_pkg::OP_DEQ: begin
        if (q_fill == 0) begin
          r.st = aqc_pkg::ST_EMPTY;
        end else begin
          q_fill--;
          // the last entry leaving sends the head back to slot 0
          q_head = (q_fill == 0) ? 0 : q_head + 1;
        end
      end
      aqc_pkg::OP_SEARCH: begin
        if (q_fill == 0) begin
          r.st = aqc_pkg::ST_EMPTY;
        end else begin
          r.st = aqc_pkg::ST_NOT_FOUND;
          for (k = 0; k < q_fill; k++) begin
            if (!hit && q_words[q_head + k] == w) begin
              hit = 1'b1;
              r.st = aqc_pkg::ST_DONE;
              r.pos = aqc_pkg::POS_W'(q_head + k);
            end
          end
        end
      end
      aqc_pkg::OP_CLEAR: begin
        q_head = 0;
        q_fill = 0;
      end
    endcase
    r.cnt = aqc_pkg::COUNT_W'(q_fill);
    r.empty = (q_fill == 0);
    r.full = (q_fill >= QDEPTH);
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  // input transactions feed the model, output transactions are checked in order
  always @(posedge clk) begin
    qres_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = queue_apply(aqc_pkg::op_t'(operation), value);
        if (pinned) want = pinned_res;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result expected none actual status %0d count %0d",
                   $time, status, count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st)     note_mismatch("status", want.st, status);
          if (position !== want.pos)  note_mismatch("position", want.pos, position);
          if (count !== want.cnt)     note_mismatch("count", want.cnt, count);
          if (is_empty !== want.empty) note_mismatch("is_empty", want.empty, is_empty);
          if (is_full !== want.full)  note_mismatch("is_full", want.full, is_full);
        end
      end
    end
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: a random stall before each result transaction, none while calm
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input transaction; valid only drops when a gap is drawn
  task automatic send(aqc_pkg::op_t op, logic [31:0] w, bit pin, qres_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    value      <= w;
    pinned     <= pin;
    pinned_res <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3, 4, 5: return word_pool[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  // scripted part: empty-queue rejects, word extremes, first match, stale
  // words after dequeue and clear, last-entry dequeue, fill to full, full
  // reject, then a few dequeues so the next enqueue has to compact
  stim_row_t script [SCRIPT_LEN] = '{
    '{aqc_pkg::OP_DEQ, 32'h0000_0000, 1, 1, '{aqc_pkg::ST_EMPTY, 5'd0, 6'd0, 1'b1, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'h0000_0000, 1, 1,
      '{aqc_pkg::ST_EMPTY, 5'd0, 6'd0, 1'b1, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'h8000_0000, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd1, 1'b0, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'h7fff_ffff, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd2, 1'b0, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'h0000_0000, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd3, 1'b0, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'hffff_ffff, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd4, 1'b0, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'h7fff_ffff, 1, 1,
      '{aqc_pkg::ST_DONE, 5'd1, 6'd4, 1'b0, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'h0001_2345, 1, 1,
      '{aqc_pkg::ST_NOT_FOUND, 5'd0, 6'd4, 1'b0, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'h8000_0000, 1, 1,
      '{aqc_pkg::ST_DONE, 5'd0, 6'd4, 1'b0, 1'b0}},
    '{aqc_pkg::OP_DEQ, 32'hffff_ffff, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd3, 1'b0, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'h8000_0000, 1, 1,
      '{aqc_pkg::ST_NOT_FOUND, 5'd0, 6'd3, 1'b0, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'hffff_ffff, 1, 1,
      '{aqc_pkg::ST_DONE, 5'd3, 6'd3, 1'b0, 1'b0}},
    '{aqc_pkg::OP_CLEAR, 32'h5a5a_a5a5, 1, 1,
      '{aqc_pkg::ST_DONE, 5'd0, 6'd0, 1'b1, 1'b0}},
    '{aqc_pkg::OP_SEARCH, 32'hffff_ffff, 1, 1,
      '{aqc_pkg::ST_EMPTY, 5'd0, 6'd0, 1'b1, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'h0000_0007, 1, 0, NOPIN},
    '{aqc_pkg::OP_DEQ, 32'h0000_0000, 1, 1, '{aqc_pkg::ST_DONE, 5'd0, 6'd0, 1'b1, 1'b0}},
    '{aqc_pkg::OP_ENQ, 32'h0000_0011, 32, 0, NOPIN},
    '{aqc_pkg::OP_ENQ, 32'hdead_beef, 1, 1,
      '{aqc_pkg::ST_FULL, 5'd0, 6'd32, 1'b0, 1'b1}},
    '{aqc_pkg::OP_SEARCH, 32'h0000_0030, 1, 1,
      '{aqc_pkg::ST_DONE, 5'd31, 6'd32, 1'b0, 1'b1}},
    '{aqc_pkg::OP_DEQ, 32'h0000_0000, 3, 0, NOPIN},
    '{aqc_pkg::OP_ENQ, 32'h0000_0055, 1, 0, NOPIN},
    '{aqc_pkg::OP_SEARCH, 32'h0000_0055, 1, 0, NOPIN},
    '{aqc_pkg::OP_SEARCH, 32'h0000_0014, 1, 0, NOPIN},
    '{aqc_pkg::OP_DEQ, 32'h0000_0000, 30, 0, NOPIN},
    '{aqc_pkg::OP_DEQ, 32'h0000_0000, 1, 1, '{aqc_pkg::ST_EMPTY, 5'd0, 6'd0, 1'b1, 1'b0}}
  };

  initial begin
    int           k;
    int           j;
    int           sent;
    int           burst_len;
    int           enq_pct;
    int           roll;
    aqc_pkg::op_t op;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < SCRIPT_LEN; k++) begin
      for (j = 0; j < script[k].reps; j++)
        send(script[k].op, script[k].word + j, script[k].pinned, script[k].res);
    end
    // sender holds off until the scripted results are all in
    wait_quiet();

    // random bursts: each picks an enqueue bias, so the queue swings between
    // empty and full and the head drifts far enough to force compaction
    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: enq_pct = 95;
        1: enq_pct = 75;
        2: enq_pct = 50;
        default: enq_pct = 25;
      endcase
      // small words make duplicates likely, so first-match order gets exercised
      for (k = 0; k < 8; k++)
        word_pool[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
      burst_len = $urandom_range(30, 90);
      for (j = 0; j < burst_len && sent < RAND_ITEMS; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < 1)
          op = aqc_pkg::OP_CLEAR;
        else if (roll < 26)
          op = aqc_pkg::OP_SEARCH;
        else if ($urandom_range(0, 99) < enq_pct)
          op = aqc_pkg::OP_ENQ;
        else
          op = aqc_pkg::OP_DEQ;
        send(op, pick_word(), 1'b0, NOPIN);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) wait_quiet();
    end

    // drain, then give the block time to show any stray result
    calm = 1'b0;
    wait_quiet();
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
